// ===== rtl/timing_event_usage_statistics_assert.svh =====
// Assertion macros shared by the statistics block.
`ifndef TIMING_EVENT_USAGE_STATISTICS_ASSERT_SVH
`define TIMING_EVENT_USAGE_STATISTICS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TES_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tes_pkg.sv =====
// Shared types and constants of the timing event usage statistics block.
package tes_pkg;

    localparam logic [11:0] GROUP_BASE   = 12'h1c0;
    localparam logic [31:0] GAP_RESET    = 32'd10000000;
    localparam logic [15:0] PERIOD_RESET = 16'd200;

    localparam int MODE_W    = 5;
    localparam int GIDX_W    = 4;   // covers up to 16 groups
    localparam int AIDX_W    = 6;   // covers up to 64 accelerators
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 8'd1;

    // Work handed from the front to the back.
    typedef struct packed {
        logic              dump;
        logic              count;
        logic [GIDX_W-1:0] gidx;
        logic [AIDX_W-1:0] acc;
        logic [MODE_W-1:0] modes;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } mod_status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_EVAL,
        F_DIV,
        F_SEND
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DUMP_RD,
        B_DUMP_OUT,
        B_CNT_RD,
        B_CNT_WR
    } back_state_t;

endpackage

// ===== rtl/tes_mod.sv =====
// Bit-serial remainder unit: cycle count modulo period, one quotient bit per cycle.
module tes_mod
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          dividend,
    input  logic [15:0]          divisor,
    output tes_pkg::mod_status_t status
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  step_reg;
    logic [15:0] rem_reg;
    logic [31:0] dvd_reg;
    logic [15:0] dsr_reg;
    logic [16:0] trial;
    logic [16:0] trial_sub;
    logic        trial_ge;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[31]};
        trial_ge  = trial >= {1'b0, dsr_reg};
        trial_sub = trial - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == 5'd31);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'd31)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= trial_ge ? trial_sub[15:0] : trial[15:0];
        end
    end

    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

endmodule

// ===== rtl/tes_front.sv =====
// Front end: accepts events, tracks machine cycles and classifies each event.
module tes_front #(
    parameter int NUM_GROUPS = 7,
    parameter int NUM_ACCELS = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic signed [63:0]               deadline,
    input  logic [11:0]                      group_id,
    input  logic [11:0]                      accel_id,
    input  logic [1:0]                       source_flags,
    input  logic [3:0]                       pulse_flags,
    input  logic                             cfg_valid,
    input  logic [tes_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_data,
    input  logic                             q_full,
    output logic                             q_push,
    output tes_pkg::cmd_t                    q_cmd
);

    tes_pkg::front_state_t state_reg, state_next;

    logic [31:0] gap_reg;
    logic [15:0] period_reg;
    logic        primed_reg;
    logic [63:0] prev_reg;
    logic [31:0] cycle_reg;
    logic        dump_reg;

    logic [63:0] ev_deadline_reg;
    logic [11:0] ev_gid_reg;
    logic [11:0] ev_acc_reg;
    logic [1:0]  ev_src_reg;
    logic [3:0]  ev_pul_reg;

    logic [63:0] diff;
    logic        open_cycle;
    logic        need_div;
    logic        ev_load;
    logic        div_start;
    logic        grp_ok;
    logic        acc_ok;

    tes_pkg::mod_status_t div_status;

    tes_mod u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cycle_reg),
        .divisor  (period_reg),
        .status   (div_status)
    );

    always_comb
    begin
        // signed difference: a wrapped or negative gap never opens a cycle
        diff       = ev_deadline_reg - prev_reg;
        open_cycle = primed_reg && !diff[63] && (diff > {32'd0, gap_reg});
        need_div   = open_cycle && (cycle_reg != '0) && (period_reg != '0);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tes_pkg::F_IDLE:
            begin
                if (push)
                    state_next = tes_pkg::F_EVAL;
            end
            tes_pkg::F_EVAL:
            begin
                state_next = need_div ? tes_pkg::F_DIV : tes_pkg::F_SEND;
            end
            tes_pkg::F_DIV:
            begin
                if (div_status.done)
                    state_next = tes_pkg::F_SEND;
            end
            tes_pkg::F_SEND:
            begin
                if (!q_full)
                    state_next = tes_pkg::F_IDLE;
            end
            default:
            begin
                state_next = tes_pkg::F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        full      = 1'b1;
        ev_load   = 1'b0;
        div_start = 1'b0;
        q_push    = 1'b0;
        case (state_reg)
            tes_pkg::F_IDLE:
            begin
                full    = 1'b0;
                ev_load = push;
            end
            tes_pkg::F_EVAL:
            begin
                div_start = need_div;
            end
            tes_pkg::F_SEND:
            begin
                q_push = !q_full;
            end
            default:
            begin
                full = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tes_pkg::F_IDLE;
            gap_reg    <= tes_pkg::GAP_RESET;
            period_reg <= tes_pkg::PERIOD_RESET;
            primed_reg <= 1'b0;
            prev_reg   <= '0;
            cycle_reg  <= '0;
            dump_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    tes_pkg::CFG_GAP:    gap_reg    <= cfg_data;
                    tes_pkg::CFG_PERIOD: period_reg <= cfg_data[15:0];
                    default:             ;
                endcase
            end
            if (state_reg == tes_pkg::F_EVAL)
            begin
                dump_reg <= 1'b0;
                if (!primed_reg)
                begin
                    prev_reg   <= ev_deadline_reg;
                    primed_reg <= 1'b1;
                end
                else if (open_cycle)
                begin
                    prev_reg  <= ev_deadline_reg;
                    cycle_reg <= cycle_reg + 32'd1;
                end
            end
            if ((state_reg == tes_pkg::F_DIV) && div_status.done)
                dump_reg <= div_status.rem_zero;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_load)
        begin
            ev_deadline_reg <= $unsigned(deadline);
            ev_gid_reg      <= group_id;
            ev_acc_reg      <= accel_id;
            ev_src_reg      <= source_flags;
            ev_pul_reg      <= pulse_flags;
        end
    end

    always_comb
    begin
        grp_ok = (ev_gid_reg >= tes_pkg::GROUP_BASE) &&
                 ({1'b0, ev_gid_reg} < ({1'b0, tes_pkg::GROUP_BASE} + 13'(NUM_GROUPS)));
        acc_ok = ev_acc_reg < 12'(NUM_ACCELS);

        q_cmd.dump  = dump_reg;
        q_cmd.count = grp_ok && acc_ok;
        q_cmd.gidx  = tes_pkg::GIDX_W'(ev_gid_reg - tes_pkg::GROUP_BASE);
        q_cmd.acc   = tes_pkg::AIDX_W'(ev_acc_reg);
        // N, S, H, R, D from bit 0 up
        q_cmd.modes = {ev_pul_reg[2], ev_pul_reg[1], ev_pul_reg[3],
                       ev_src_reg[1], ev_src_reg[0]};
    end

endmodule

// ===== rtl/tes_queue.sv =====
// Two-entry command queue between the front and the back.
module tes_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tes_pkg::cmd_t din,
    output logic          full,
    input  logic          pop,
    output tes_pkg::cmd_t dout,
    output logic          empty
);

    tes_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= din;
    end

endmodule

// ===== rtl/tes_back.sv =====
// Back end: statistics store, table dump and per-event counting.
`include "timing_event_usage_statistics_assert.svh"

module tes_back #(
    parameter int NUM_GROUPS  = 7,
    parameter int NUM_ACCELS  = 16,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  tes_pkg::cmd_t q_head,
    input  logic          q_empty,
    output logic          q_pop,
    output logic          empty,
    input  logic          pop,
    output logic [3:0]    accel_index,
    output logic [6:0]    group_mask,
    output logic [15:0]   last_count,
    output logic [4:0]    mode_flags,
    output logic          last_row
);

    localparam int AW   = (NUM_ACCELS > 1) ? $clog2(NUM_ACCELS) : 1;
    localparam int CW   = COUNT_WIDTH;
    localparam int MOFF = NUM_GROUPS * CW;
    localparam int RW   = MOFF + tes_pkg::MODE_W;
    localparam int PADG = (NUM_GROUPS > 7) ? NUM_GROUPS : 7;
    localparam int PADC = (CW > 16) ? CW : 16;
    localparam int PADA = (AW > 4) ? AW : 4;

    tes_pkg::back_state_t state_reg, state_next;

    tes_pkg::cmd_t        cmd_reg;
    logic [AW-1:0]        idx_reg;
    logic [NUM_ACCELS-1:0] row_valid_reg;
    logic [RW-1:0]        mem_array [NUM_ACCELS];
    logic [RW-1:0]        rd_data_reg;
    logic                 rd_vld_reg;
    logic                 out_valid_reg;

    logic [3:0]           accel_index_reg;
    logic [6:0]           group_mask_reg;
    logic [15:0]          last_count_reg;
    logic [4:0]           mode_flags_reg;
    logic                 last_row_reg;

    logic [AW-1:0]        cmd_acc;
    logic [AW-1:0]        rd_addr;
    logic                 rd_en;
    logic                 we;
    logic                 out_load;
    logic                 last_idx;

    logic [RW-1:0]        row;
    logic [RW-1:0]        wr_row;
    logic [CW-1:0]        cnt [NUM_GROUPS];
    logic [NUM_GROUPS-1:0] nz;
    logic [CW-1:0]        last_cnt;
    logic [PADG-1:0]      nz_pad;
    logic [PADC-1:0]      last_pad;
    logic [PADA-1:0]      idx_pad;

    assign cmd_acc  = cmd_reg.acc[AW-1:0];
    assign last_idx = (idx_reg == AW'(NUM_ACCELS - 1));

    // row decode; a row not written since the last clear reads as zero
    always_comb
    begin
        row      = rd_vld_reg ? rd_data_reg : '0;
        last_cnt = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            cnt[g] = row[g*CW +: CW];
            nz[g]  = (cnt[g] != '0);
        end
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            if (nz[g])
                last_cnt = cnt[g];
        end
        nz_pad   = PADG'(nz);
        last_pad = PADC'(last_cnt);
        idx_pad  = PADA'(idx_reg);
    end

    // saturating increment of the selected group, sticky mode OR
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            if (tes_pkg::GIDX_W'(g) == cmd_reg.gidx)
                wr_row[g*CW +: CW] = (cnt[g] == '1) ? cnt[g] : cnt[g] + CW'(1);
            else
                wr_row[g*CW +: CW] = cnt[g];
        end
        wr_row[MOFF +: tes_pkg::MODE_W] = row[MOFF +: tes_pkg::MODE_W] | cmd_reg.modes;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tes_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_head.dump)
                        state_next = tes_pkg::B_DUMP_RD;
                    else if (q_head.count)
                        state_next = tes_pkg::B_CNT_RD;
                end
            end
            tes_pkg::B_DUMP_RD:
            begin
                state_next = tes_pkg::B_DUMP_OUT;
            end
            tes_pkg::B_DUMP_OUT:
            begin
                if (out_load)
                begin
                    if (!last_idx)
                        state_next = tes_pkg::B_DUMP_RD;
                    else if (cmd_reg.count)
                        state_next = tes_pkg::B_CNT_RD;
                    else
                        state_next = tes_pkg::B_IDLE;
                end
            end
            tes_pkg::B_CNT_RD:
            begin
                state_next = tes_pkg::B_CNT_WR;
            end
            tes_pkg::B_CNT_WR:
            begin
                state_next = tes_pkg::B_IDLE;
            end
            default:
            begin
                state_next = tes_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = idx_reg;
        we       = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            tes_pkg::B_IDLE:
            begin
                q_pop = !q_empty;
            end
            tes_pkg::B_DUMP_RD:
            begin
                rd_en = 1'b1;
            end
            tes_pkg::B_DUMP_OUT:
            begin
                out_load = !out_valid_reg || pop;
            end
            tes_pkg::B_CNT_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = cmd_acc;
            end
            tes_pkg::B_CNT_WR:
            begin
                we = 1'b1;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tes_pkg::B_IDLE;
            idx_reg       <= '0;
            row_valid_reg <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rd_en)
                rd_vld_reg <= row_valid_reg[rd_addr];
            if (out_load)
            begin
                idx_reg <= last_idx ? '0 : idx_reg + AW'(1);
                out_valid_reg <= 1'b1;
            end
            else if (pop)
                out_valid_reg <= 1'b0;
            // clear the store once the last row of a dump is out
            if (out_load && last_idx)
                row_valid_reg <= '0;
            else if (we)
                row_valid_reg[cmd_acc] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= q_head;
        if (out_load)
        begin
            accel_index_reg <= idx_pad[3:0];
            group_mask_reg  <= nz_pad[6:0];
            last_count_reg  <= last_pad[15:0];
            mode_flags_reg  <= row[MOFF +: tes_pkg::MODE_W];
            last_row_reg    <= last_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem_array[cmd_acc] <= wr_row;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem_array[rd_addr];
    end

    assign empty       = !out_valid_reg;
    assign accel_index = accel_index_reg;
    assign group_mask  = group_mask_reg;
    assign last_count  = last_count_reg;
    assign mode_flags  = mode_flags_reg;
    assign last_row    = last_row_reg;

    `TES_ASSERT_NXT(a_result_held, clk, rst_n, out_valid_reg && !pop, out_valid_reg, "result item lost while stalled")
    `TES_ASSERT_NXT(a_store_cleared, clk, rst_n, out_load && last_idx, row_valid_reg == '0, "store not cleared after dump")
    `TES_ASSERT_NXT(a_count_written, clk, rst_n, state_reg == tes_pkg::B_CNT_WR, row_valid_reg[cmd_acc] && (state_reg == tes_pkg::B_IDLE), "counted row not marked valid")

endmodule

// ===== rtl/timing_event_usage_statistics.sv =====
// Timing event usage statistics: top level.
//
// Input channel: push/full. One event (deadline, group_id, accel_id,
// source_flags, pulse_flags) is taken when push is high and full is low.
// Result channel: empty/pop. While empty is low the oldest dump row is on
// accel_index..last_row; it leaves when pop is high.
// Config channel: cfg_valid/cfg_ready (ready always high); cfg_index 0 is
// the gap threshold, 1 the period. Write only while the block is idle.
// Front: each event passes F_IDLE, F_EVAL and F_SEND, plus F_DIV for the
// bit-serial remainder of the cycle count by the period whenever a new
// machine cycle opens with a nonzero count and a nonzero period.
// A two-entry queue lets the front run ahead of the back.
// Back: counting is a read-modify-write of one store row; a dump reads and
// outputs each row, and the store clears in the same cycle as the last row.
// Reset clears control state and row-valid bits at once; no clearing pass.
// A stalled result blocks the back; the front and queue keep taking events
// until the queue fills, then full stays high.
module timing_event_usage_statistics #(
    parameter int NUM_GROUPS  = 7,
    parameter int NUM_ACCELS  = 16,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [63:0]            deadline,
    input  logic [11:0]                   group_id,
    input  logic [11:0]                   accel_id,
    input  logic [1:0]                    source_flags,
    input  logic [3:0]                    pulse_flags,
    output logic                          empty,
    input  logic                          pop,
    output logic [3:0]                    accel_index,
    output logic [6:0]                    group_mask,
    output logic [15:0]                   last_count,
    output logic [4:0]                    mode_flags,
    output logic                          last_row,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    tes_pkg::cmd_t f_cmd;
    tes_pkg::cmd_t q_head;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;

    assign cfg_ready = 1'b1;

    tes_front #(
        .NUM_GROUPS (NUM_GROUPS),
        .NUM_ACCELS (NUM_ACCELS)
    ) u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .deadline     (deadline),
        .group_id     (group_id),
        .accel_id     (accel_id),
        .source_flags (source_flags),
        .pulse_flags  (pulse_flags),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (f_cmd)
    );

    tes_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (f_cmd),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_head),
        .empty (q_empty)
    );

    tes_back #(
        .NUM_GROUPS  (NUM_GROUPS),
        .NUM_ACCELS  (NUM_ACCELS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_head      (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .accel_index (accel_index),
        .group_mask  (group_mask),
        .last_count  (last_count),
        .mode_flags  (mode_flags),
        .last_row    (last_row)
    );

endmodule
